[rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window mean / min / max block
// Field widths, default depth, reset window length and sequencer states.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;

  // Default window depth and reset length
  localparam int MAX_WINDOW_DEF = 64;
  localparam int LEN_RESET      = 8;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAUNCH,
    S_DIV,
    S_DONE
  } state_t;

endpackage

[rtl/sliding_window_mean_min_max.sv]
// ----------------------------------------------------------------------------
// sliding_window_mean_min_max: moving average with window min and max
// Shifts each Q3.12 sample into a window of cfg length and reports the
// truncated mean, the maximum and the minimum of that window.
// ----------------------------------------------------------------------------
// One request steps through the sequencer, L being the window length and
// SUM_W the sum width (22 at the default depth of 64): it shifts the
// sample into the cell row, rotates the row's L-entry window past cell 0
// to build the sum, max and min, launches the serial divider, which forms
// the SUM_W-bit mean one bit per cycle and flags done, and then loads the
// output register. Only one request is in
// work at a time; the result waits in an output register, so the next
// request is taken while the previous result is still stalled. The window
// clears to zero at reset, so early results count those zeros. A length of
// 0 is held as 1 and one above MAX_WINDOW as MAX_WINDOW; changing the length
// does not flush the window.
// ----------------------------------------------------------------------------
module sliding_window_mean_min_max
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data,
  // sample requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_window_mean,
  output logic signed [SAMPLE_W-1:0] out_window_max,
  output logic signed [SAMPLE_W-1:0] out_window_min
);

  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int LEN_RST = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [LEN_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic signed [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        mean_r, mean_nxt;
  logic [SAMPLE_W-1:0]        max_r, max_nxt;
  logic [SAMPLE_W-1:0]        min_r, min_nxt;

  logic                       accept;
  logic                       step;
  logic                       div_start;
  logic                       div_done;
  logic                       out_free;
  logic                       scan_last;
  logic [SUM_W-1:0]           div_mag;
  logic [SUM_W-1:0]           div_quot;
  logic [SUM_W-1:0]           mean_full;
  logic [SAMPLE_W-1:0]        tail_val;
  logic signed [SAMPLE_W-1:0] head;
  logic [31:0]                cfg_ext;
  logic [SAMPLE_W-1:0]        cell_q [MAX_WINDOW];

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_last = (cnt_r == len_r - LEN_W'(1));
  assign head      = $signed(cell_q[0]);

  // cell row: shift in on accept, rotate the window during the scan
  assign tail_val = (state_r == S_IDLE) ? in_sample : cell_q[0];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_W-1:0] nbr;
    if (i == MAX_WINDOW - 1) begin : g_end
      assign nbr = tail_val;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    swm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .len      (len_r),
      .next_val (nbr),
      .tail_val (tail_val),
      .q        (cell_q[i])
    );
  end

  // mean: magnitude through the serial divider, sign restored after
  assign div_mag = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;

  swm_div #(
    .NUM_W (SUM_W),
    .DEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (len_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign mean_full = sum_r[SUM_W-1] ? (~div_quot + SUM_W'(1)) : div_quot;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_SCAN;
      S_SCAN:   if (scan_last) state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    step      = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        step     = in_valid;
      end
      S_SCAN:   step = 1'b1;
      S_LAUNCH: div_start = 1'b1;
      S_DIV:    ;
      S_DONE:   ;
      default:  ;
    endcase
  end

  // window length register, clamped to 1..MAX_WINDOW
  always_comb begin
    cfg_ext = 32'(cfg_wr_data);
    len_nxt = len_r;
    if (cfg_wr_en) begin
      if (cfg_ext == 32'd0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_ext > 32'(MAX_WINDOW)) begin
        len_nxt = LEN_W'(MAX_WINDOW);
      end else begin
        len_nxt = LEN_W'(cfg_ext);
      end
    end
  end

  // scan accumulation: sum, max and min of the entry at cell 0
  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    if (state_r == S_IDLE) begin
      cnt_nxt = '0;
    end else if (state_r == S_SCAN) begin
      cnt_nxt = cnt_r + LEN_W'(1);
      if (cnt_r == '0) begin
        sum_nxt = SUM_W'(head);
        hi_nxt  = head;
        lo_nxt  = head;
      end else begin
        sum_nxt = sum_r + SUM_W'(head);
        if (head > hi_r) hi_nxt = head;
        if (head < lo_r) lo_nxt = head;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    mean_nxt      = mean_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      mean_nxt      = mean_full[SAMPLE_W-1:0];
      max_nxt       = hi_r;
      min_nxt       = lo_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(LEN_RST);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    mean_r <= mean_nxt;
    max_r  <= max_nxt;
    min_r  <= min_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_window_mean = mean_r;
  assign out_window_max  = max_r;
  assign out_window_min  = min_r;

  // one request at a time: an accepted request blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted while another is in work");

  // a result never has max below min
  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_max >= out_window_min))
    else $error("window max below window min");

  // the mean lies between min and max
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_mean <= out_window_max &&
                   out_window_mean >= out_window_min))
    else $error("window mean outside min..max");

  // the length register never leaves 1..MAX_WINDOW
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (len_r != '0 && len_r <= LEN_W'(MAX_WINDOW)))
    else $error("window length out of range");

  // divider only completes while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

endmodule

[rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one window entry of the cell row
// Holds one sample. When the row steps and the cell lies inside the window,
// it takes its upper neighbor's value, or the tail value if it is the last
// cell of the window.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int LEN_W = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [LEN_W-1:0]    len,
  input  logic [SAMPLE_W-1:0] next_val,
  input  logic [SAMPLE_W-1:0] tail_val,
  output logic [SAMPLE_W-1:0] q
);

  logic [SAMPLE_W-1:0] q_r;
  logic [SAMPLE_W-1:0] q_nxt;
  logic                in_win;
  logic                at_tail;

  // position of this cell relative to the current window
  assign in_win  = (LEN_W'(IDX) < len);
  assign at_tail = (len == LEN_W'(IDX + 1));

  always_comb begin
    q_nxt = q_r;
    if (step && in_win) begin
      q_nxt = at_tail ? tail_val : next_val;
    end
  end

  // window store clears to zero at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/swm_div.sv]
// ----------------------------------------------------------------------------
// swm_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, most significant first.
// Raises done for one cycle after the last bit; quot holds until next start.
// ----------------------------------------------------------------------------
module swm_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  // one restoring step
  assign trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

[tb/sv/sliding_window_mean_min_max_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_mean_min_max_test: self-checking bench for the window block
// Streams Q3.12 samples through the block under several window lengths,
// predicts mean, max and min from a local copy of the window and checks
// every result in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module sliding_window_mean_min_max_test;
  import swm_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t mean;
    sample_t hi;
    sample_t lo;
  } window_stats_t;

  localparam int STALL_LIMIT = 3000;  // cycles with nothing accepted while busy
  localparam int LONG_HOLD   = 400;   // long receiver hold-off
  localparam int SETTLE      = 100;   // worst-case request latency plus margin
  localparam int MAX_REPORTS = 100;

  // DUT interface
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sample_t             in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sample_t             out_window_mean;
  sample_t             out_window_max;
  sample_t             out_window_min;

  // Bench state
  sample_t             pending_samples[$];
  window_stats_t       expected_stats[$];
  sample_t             model_window[MAX_WINDOW_DEF];
  int                  model_len = LEN_RESET;
  int                  error_count = 0;
  logic                in_took = 1'b0;
  logic                out_took = 1'b0;
  bit                  send_burst = 1'b0;
  bit                  recv_burst = 1'b0;
  int                  send_gap = 0;
  int                  stall_left = 0;
  int                  hold_left = 0;
  int                  hold_ask = 0;
  int                  hold_seen = 0;
  int                  idle_cycles = 0;

  sliding_window_mean_min_max uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_mean (out_window_mean),
    .out_window_max  (out_window_max),
    .out_window_min  (out_window_min)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register value to effective window length
  function automatic int length_from_reg(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
    return int'(v);
  endfunction

  // Shift one sample into the window and measure it
  function automatic window_stats_t shift_and_measure(sample_t s);
    window_stats_t r;
    longint        total;
    sample_t       v;
    for (int i = 0; i + 1 < model_len; i++) model_window[i] = model_window[i + 1];
    model_window[model_len - 1] = s;
    total = 0;
    r.hi = model_window[0];
    r.lo = model_window[0];
    for (int i = 0; i < model_len; i++) begin
      v = model_window[i];
      total += v;
      if (v > r.hi) r.hi = v;
      if (v < r.lo) r.lo = v;
    end
    // longint division truncates toward zero
    r.mean = sample_t'(total / model_len);
    return r;
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h7fff);
      1:       return sample_t'(16'h8000);
      2, 3:    return sample_t'($urandom_range(0, 512) - 256);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Sender: holds a stalled request, otherwise waits out its gap and loads the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_took) begin
      // request still waiting, keep it
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_samples.size() != 0) begin
      in_valid  <= 1'b1;
      in_sample <= pending_samples.pop_front();
      send_gap  <= send_burst ? 0 : $urandom_range(0, 6);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random wait per result plus the occasional long hold-off
  always @(negedge clk) begin : rx_pace
    int n;
    n = out_took ? (recv_burst ? 0 : $urandom_range(0, 6)) : stall_left;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      hold_left  <= LONG_HOLD;
      out_stall  <= 1'b1;
      stall_left <= n;
    end else if (hold_left > 0) begin
      out_stall  <= 1'b1;
      hold_left  <= hold_left - 1;
      stall_left <= n;
    end else if (n > 0) begin
      out_stall  <= 1'b1;
      stall_left <= n - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end
  end

  // Monitor: track config, predict on each accepted request, check each result
  always @(posedge clk) begin : monitor
    window_stats_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
      model_len = LEN_RESET;
      for (int i = 0; i < MAX_WINDOW_DEF; i++) model_window[i] = '0;
    end else begin
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (cfg_wr_en) model_len = length_from_reg(cfg_wr_data);
      if (in_valid && !in_stall) expected_stats.push_back(shift_and_measure(in_sample));
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          error_count++;
          $error("result with no request outstanding: mean %0d max %0d min %0d",
                 out_window_mean, out_window_max, out_window_min);
        end else begin
          want = expected_stats.pop_front();
          if (out_window_mean !== want.mean) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("window_mean: expected %0d, got %0d", want.mean, out_window_mean);
          end
          if (out_window_max !== want.hi) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("window_max: expected %0d, got %0d", want.hi, out_window_max);
          end
          if (out_window_min !== want.lo) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $error("window_min: expected %0d, got %0d", want.lo, out_window_min);
          end
        end
      end
    end
  end

  // Watchdog: no progress while work is outstanding
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (pending_samples.size() != 0 || in_valid || expected_stats.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Wait until every request is sent and every result is back, then settle
  task automatic drain_all();
    do @(posedge clk); while (pending_samples.size() != 0 || in_valid);
    do @(negedge clk); while (expected_stats.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic queue_random(int count);
    @(posedge clk);
    repeat (count) pending_samples.push_back(draw_sample());
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] len_plan[$];
    int               phase;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset length of 8: zeros from reset show up in the first windows
    @(posedge clk);
    pending_samples = '{16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
                        -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001, 16'sh5555,
                        -16'sh5556, 16'sh2aaa};
    drain_all();

    // Zero written: held as a window of one
    write_length('0);
    @(posedge clk);
    pending_samples = '{16'sh7fff, -16'sh8000, -16'sh0001};
    drain_all();

    // Above the maximum: saturates to full depth, stale entries re-enter
    write_length(7'h7f);
    @(posedge clk);
    pending_samples = '{-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh0000};
    drain_all();

    // Random phases over a spread of lengths, no flush between them
    len_plan = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd0, 7'd3, 7'd8, 7'd63, 7'd65};
    repeat (6) len_plan.push_back(CFG_W'($urandom_range(0, 127)));
    phase = 0;
    foreach (len_plan[k]) begin
      write_length(len_plan[k]);
      send_burst = (phase % 4 == 1) || (phase % 4 == 3);
      recv_burst = (phase % 4 == 2) || (phase % 4 == 3);
      queue_random(100);
      // full-depth window with a back-to-back sender: hold results long enough
      // for the block to fill and push back on requests
      if (phase == 1) begin
        repeat (20) @(posedge clk);
        hold_ask = hold_ask + 1;
      end
      drain_all();
      phase++;
    end

    send_burst = 1'b0;
    recv_burst = 1'b0;
    drain_all();
    repeat (SETTLE) @(posedge clk);
    if (expected_stats.size() != 0) begin
      error_count++;
      $error("%0d results never arrived", expected_stats.size());
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
